// File: rtl/core/assert_macros.svh
// Assertion macros used by the top-level RTL file.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GKA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define GKA_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define GKA_ASSERT(lbl, clk, rst, prop)
`define GKA_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// File: rtl/core/gka_pkg.sv
// Types and constants of the gyro angle integrator.
// No dependencies.
package gka_pkg;
   localparam int unsigned SER_W   = 57;   // serial datapath width
   localparam int unsigned DIVR_W  = 34;   // divisor width
   localparam int unsigned MULB_W  = 17;   // multiplier operand width
   localparam logic [24:0] ANGLE_MOD = 25'd23592960;
   localparam logic [16:0] ONE_Q16   = 17'h10000;

   localparam logic [2:0] REG_ROLL_OFS  = 3'd0;
   localparam logic [2:0] REG_PITCH_OFS = 3'd1;
   localparam logic [2:0] REG_YAW_OFS   = 3'd2;
   localparam logic [2:0] REG_SCALE     = 3'd3;
   localparam logic [2:0] REG_QNOISE    = 3'd4;
   localparam logic [2:0] REG_RNOISE    = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_K_DIV,
      ST_P_MUL,
      ST_X_MUL,
      ST_I_MUL1,
      ST_I_MUL2,
      ST_I_DIV,
      ST_I_MOD,
      ST_OUT
   } gka_state_type;
endpackage

// File: rtl/core/gka_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on gka_pkg.
module gka_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [gka_pkg::SER_W-1:0]   a,
   input  logic [gka_pkg::MULB_W-1:0]  b,
   output logic                        done,
   output logic [gka_pkg::SER_W-1:0]   p
);
   import gka_pkg::*;

   logic [SER_W-1:0]  acc_ff, ma_ff;
   logic [MULB_W-1:0] mb_ff;
   logic [4:0]        cnt_ff;
   logic              done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            acc_ff <= '0;
            ma_ff  <= a;
            mb_ff  <= b;
            cnt_ff <= 5'(MULB_W);
         end else if (cnt_ff != '0) begin
            if (mb_ff[0]) acc_ff <= acc_ff + ma_ff;
            ma_ff  <= {ma_ff[SER_W-2:0], 1'b0};
            mb_ff  <= {1'b0, mb_ff[MULB_W-1:1]};
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) done_ff <= 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign p    = acc_ff;
endmodule

// File: rtl/core/gka_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on gka_pkg.
module gka_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [gka_pkg::SER_W-1:0]   n,
   input  logic [gka_pkg::DIVR_W-1:0]  d,
   output logic                        done,
   output logic [gka_pkg::SER_W-1:0]   q,
   output logic [gka_pkg::DIVR_W-1:0]  r
);
   import gka_pkg::*;

   logic [SER_W-1:0]  quo_ff;
   logic [DIVR_W-1:0] rem_ff, d_ff;
   logic [5:0]        cnt_ff;
   logic              done_ff;
   logic [DIVR_W:0]   trial;

   assign trial = {rem_ff, quo_ff[SER_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quo_ff <= n;
            rem_ff <= '0;
            d_ff   <= d;
            cnt_ff <= 6'(SER_W);
         end else if (cnt_ff != '0) begin
            if (trial >= {1'b0, d_ff}) begin
               rem_ff <= DIVR_W'(trial - {1'b0, d_ff});
               quo_ff <= {quo_ff[SER_W-2:0], 1'b1};
            end else begin
               rem_ff <= trial[DIVR_W-1:0];
               quo_ff <= {quo_ff[SER_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) done_ff <= 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign q    = quo_ff;
   assign r    = rem_ff;
endmodule

// File: rtl/core/gyro_kalman_angle_integrator.sv
// Top level of the gyro angle integrator: offsets, scalar Kalman on yaw/pitch, integration.
// Depends on gka_pkg, gka_mul, gka_div and assert_macros.svh.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  raw rates, elapsed_ms, zero flags
//   rsp      out        rsp_valid/rsp_stall  two angles, three corrected rates
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// Per axis a request runs one divide for the gain, four multiplies and two divides
// (by 1000, mod 360 degrees), all on the shared serial multiplier and divider, then
// the output state ST_OUT, before the next request can be taken. Synchronous reset
// clears control, offsets and filter state and loads the scale and noise defaults;
// datapath and output registers are not reset. A new request is taken while the
// previous result waits on stall; the next waits in ST_OUT until that one is taken.
`include "assert_macros.svh"
module gyro_kalman_angle_integrator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic signed [23:0] req_roll_rate_raw,
   input  logic signed [23:0] req_pitch_rate_raw,
   input  logic signed [23:0] req_yaw_rate_raw,
   input  logic [15:0] req_elapsed_ms,
   input  logic        req_zero_yaw,
   input  logic        req_zero_pitch,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [24:0] rsp_yaw_angle,
   output logic [24:0] rsp_pitch_angle,
   output logic signed [24:0] rsp_roll_rate,
   output logic signed [24:0] rsp_pitch_rate,
   output logic signed [24:0] rsp_yaw_rate,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);
   import gka_pkg::*;

   gka_state_type state_ff, state_in;
   logic          start_ff;

   logic [23:0] roll_ofs_ff, pitch_ofs_ff, yaw_ofs_ff, qn_ff, rn_ff;
   logic [15:0] scale_ff;

   logic [31:0] var_ff [2];
   logic [24:0] filt_ff [2];
   logic [24:0] angle_ff [2];

   logic [24:0] roll_c_ff, pitch_c_ff, yaw_c_ff;
   logic [15:0] ms_ff;
   logic        ax_ff;
   logic [16:0] k_ff;
   logic [SER_W-1:0] prod_ff;

   logic        rsp_valid_ff;
   logic [24:0] o_yaw_ff, o_pitch_ff, o_roll_r_ff, o_pitch_r_ff, o_yaw_r_ff;

   // serial unit hookup
   logic              mul_done, div_done;
   logic [SER_W-1:0]  mul_a, mul_p, div_n, div_q;
   logic [MULB_W-1:0] mul_b;
   logic [DIVR_W-1:0] div_d, div_r;
   logic              mul_start, div_start;

   logic [32:0] pp;
   logic [33:0] psum;
   logic [24:0] meas, x_cur, x_abs;
   logic [25:0] diff, diff_abs, x_new;
   logic [SER_W-1:0] rnd;
   logic [40:0] pn;
   logic [26:0] ang_s;
   logic        sub_inc;
   logic        fin;
   logic        angles_ok;

   assign pp    = {1'b0, var_ff[ax_ff]} + {9'b0, qn_ff};
   assign psum  = {1'b0, pp} + {10'b0, rn_ff};
   assign meas  = ax_ff ? pitch_c_ff : yaw_c_ff;
   assign x_cur = filt_ff[ax_ff];
   assign x_abs = x_cur[24] ? 25'(-x_cur) : x_cur;
   assign diff  = {meas[24], meas} - {x_cur[24], x_cur};
   assign diff_abs = diff[25] ? 26'(-diff) : diff;
   assign rnd   = mul_p + SER_W'(32768);
   assign pn    = rnd[56:16];
   assign x_new = diff[25] ? ({x_cur[24], x_cur} - rnd[41:16])
                           : ({x_cur[24], x_cur} + rnd[41:16]);
   // yaw subtracts the increment, pitch adds it
   assign sub_inc = x_cur[24] ^ ~ax_ff;
   assign ang_s = sub_inc ? ({2'b0, angle_ff[ax_ff]} - {2'b0, div_r[24:0]})
                          : ({2'b0, angle_ff[ax_ff]} + {2'b0, div_r[24:0]});
   assign fin   = !rsp_valid_ff || !rsp_stall;
   assign angles_ok = (rsp_yaw_angle < ANGLE_MOD) && (rsp_pitch_angle < ANGLE_MOD);

   // operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      div_n = '0;
      div_d = '0;
      case (state_ff)
         ST_K_DIV: begin
            div_n = SER_W'({pp, 16'b0});
            div_d = psum;
         end
         ST_P_MUL: begin
            mul_a = SER_W'(pp);
            mul_b = ONE_Q16 - k_ff;
         end
         ST_X_MUL: begin
            mul_a = SER_W'(diff_abs);
            mul_b = k_ff;
         end
         ST_I_MUL1: begin
            mul_a = SER_W'(x_abs);
            mul_b = {1'b0, ms_ff};
         end
         ST_I_MUL2: begin
            mul_a = prod_ff;
            mul_b = {1'b0, scale_ff};
         end
         ST_I_DIV: begin
            div_n = prod_ff;
            div_d = DIVR_W'(1000);
         end
         ST_I_MOD: begin
            div_n = prod_ff;
            div_d = DIVR_W'(ANGLE_MOD);
         end
         default: ;
      endcase
   end

   assign mul_start = start_ff && (state_ff == ST_P_MUL || state_ff == ST_X_MUL ||
                                   state_ff == ST_I_MUL1 || state_ff == ST_I_MUL2);
   assign div_start = start_ff && (state_ff == ST_K_DIV || state_ff == ST_I_DIV ||
                                   state_ff == ST_I_MOD);

   gka_mul u_mul (
      .clock (clock), .reset (reset), .start (mul_start),
      .a (mul_a), .b (mul_b), .done (mul_done), .p (mul_p)
   );

   gka_div u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .n (div_n), .d (div_d), .done (div_done), .q (div_q), .r (div_r)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_K_DIV;
         ST_K_DIV:  if (div_done) state_in = ST_P_MUL;
         ST_P_MUL:  if (mul_done) state_in = ST_X_MUL;
         ST_X_MUL:  if (mul_done) state_in = ST_I_MUL1;
         ST_I_MUL1: if (mul_done) state_in = ST_I_MUL2;
         ST_I_MUL2: if (mul_done) state_in = ST_I_DIV;
         ST_I_DIV:  if (div_done) state_in = ST_I_MOD;
         ST_I_MOD:  if (div_done) state_in = ax_ff ? ST_OUT : ST_K_DIV;
         ST_OUT:    if (fin) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ax_ff        <= 1'b0;
         roll_ofs_ff  <= '0;
         pitch_ofs_ff <= '0;
         yaw_ofs_ff   <= '0;
         scale_ff     <= 16'd6349;
         qn_ff        <= 24'd6554;
         rn_ff        <= 24'd655360;
         for (int i = 0; i < 2; i++) begin
            var_ff[i]   <= '0;
            filt_ff[i]  <= '0;
            angle_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         start_ff <= (state_in != state_ff);
         if (state_ff == ST_OUT && fin) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;

         if (csr_valid) begin
            case (csr_index)
               REG_ROLL_OFS:  roll_ofs_ff  <= csr_data;
               REG_PITCH_OFS: pitch_ofs_ff <= csr_data;
               REG_YAW_OFS:   yaw_ofs_ff   <= csr_data;
               REG_SCALE:     scale_ff     <= csr_data[15:0];
               REG_QNOISE:    qn_ff        <= csr_data;
               REG_RNOISE:    rn_ff        <= csr_data;
               default: ;
            endcase
         end

         case (state_ff)
            ST_IDLE: if (req_valid) begin
               roll_c_ff  <= {req_roll_rate_raw[23], req_roll_rate_raw}
                             - {roll_ofs_ff[23], roll_ofs_ff};
               pitch_c_ff <= {req_pitch_rate_raw[23], req_pitch_rate_raw}
                             - {pitch_ofs_ff[23], pitch_ofs_ff};
               yaw_c_ff   <= {req_yaw_rate_raw[23], req_yaw_rate_raw}
                             - {yaw_ofs_ff[23], yaw_ofs_ff};
               ms_ff <= req_elapsed_ms;
               ax_ff <= 1'b0;
               if (req_zero_yaw)   angle_ff[0] <= '0;
               if (req_zero_pitch) angle_ff[1] <= '0;
            end
            ST_K_DIV: if (div_done) begin
               k_ff <= (psum == '0) ? 17'd0 : div_q[16:0];
            end
            ST_P_MUL: if (mul_done) begin
               var_ff[ax_ff] <= (pn[40:32] != '0) ? 32'hFFFF_FFFF : pn[31:0];
            end
            ST_X_MUL: if (mul_done) begin
               filt_ff[ax_ff] <= x_new[24:0];
            end
            ST_I_MUL1: if (mul_done) prod_ff <= mul_p;
            ST_I_MUL2: if (mul_done) prod_ff <= mul_p + SER_W'(500);
            ST_I_DIV:  if (div_done) prod_ff <= div_q;
            ST_I_MOD: if (div_done) begin
               if (ang_s[26])
                  angle_ff[ax_ff] <= 25'(ang_s + {2'b0, ANGLE_MOD});
               else if (ang_s >= {2'b0, ANGLE_MOD})
                  angle_ff[ax_ff] <= 25'(ang_s - {2'b0, ANGLE_MOD});
               else
                  angle_ff[ax_ff] <= ang_s[24:0];
               ax_ff <= 1'b1;
            end
            ST_OUT: if (fin) begin
               o_yaw_ff     <= angle_ff[0];
               o_pitch_ff   <= angle_ff[1];
               o_roll_r_ff  <= roll_c_ff;
               o_pitch_r_ff <= pitch_c_ff;
               o_yaw_r_ff   <= yaw_c_ff;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_yaw_angle   = o_yaw_ff;
   assign rsp_pitch_angle = o_pitch_ff;
   assign rsp_roll_rate   = o_roll_r_ff;
   assign rsp_pitch_rate  = o_pitch_r_ff;
   assign rsp_yaw_rate    = o_yaw_r_ff;

   `GKA_ASSERT(a_start_gain, clock, reset, (req_valid && !req_stall) |=> state_ff == ST_K_DIV)
   `GKA_ASSERT(a_gain_range, clock, reset, (state_ff == ST_P_MUL) |-> (k_ff <= ONE_Q16))
   `GKA_ASSERT(a_angle_range, clock, reset, rsp_valid |-> angles_ok)
endmodule

// File: tb/tb.sv
// Testbench for gyro_kalman_angle_integrator: offset removal, yaw/pitch Kalman smoothing
// and angle integration, checked against an in-bench predictor. Depends on gka_pkg.
`timescale 1ns / 100ps
module tb;
   import gka_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 20000;
   localparam longint ANGLE_WRAP = 64'd23592960;

   typedef struct packed {
      logic signed [23:0] roll_raw;
      logic signed [23:0] pitch_raw;
      logic signed [23:0] yaw_raw;
      logic [15:0] ms;
      logic zero_yaw;
      logic zero_pitch;
   } gyro_req_t;

   typedef struct packed {
      logic [24:0] yaw_angle;
      logic [24:0] pitch_angle;
      logic [24:0] roll_rate;
      logic [24:0] pitch_rate;
      logic [24:0] yaw_rate;
   } gyro_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [23:0] req_roll_rate_raw = '0;
   logic signed [23:0] req_pitch_rate_raw = '0;
   logic signed [23:0] req_yaw_rate_raw = '0;
   logic [15:0] req_elapsed_ms = '0;
   logic req_zero_yaw = 1'b0;
   logic req_zero_pitch = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [24:0] rsp_yaw_angle, rsp_pitch_angle;
   logic signed [24:0] rsp_roll_rate, rsp_pitch_rate, rsp_yaw_rate;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [23:0] csr_data = '0;

   gyro_kalman_angle_integrator dut (.*);

   always #10 clock = ~clock;

   // predictor state
   logic signed [23:0] ofs_roll, ofs_pitch, ofs_yaw;
   logic [15:0] scale;
   logic [23:0] q_noise, r_noise;
   logic [31:0] variance [2];
   logic signed [24:0] est_rate [2];
   logic [24:0] angle [2];

   gyro_req_t pending_reqs [$];
   gyro_rsp_t expected_rsps [$];
   int unsigned errors = 0;
   int unsigned n_reqs = 0, n_rsps = 0;
   int unsigned idle_cycles = 0;
   bit hold_reqs = 1'b0;
   int unsigned req_gap = 0, rsp_gap = 0;

   function automatic longint round_div(longint v, longint d);
      longint mag;
      mag = (v < 0) ? -v : v;
      mag = (mag + d / 2) / d;
      return (v < 0) ? -mag : mag;
   endfunction

   function automatic void filter_axis(int ax, longint meas);
      longint pp, sum, k, pn, x;
      pp = longint'(variance[ax]) + longint'(q_noise);
      sum = pp + longint'(r_noise);
      k = (sum != 0) ? (pp <<< 16) / sum : 0;
      pn = (pp * (65536 - k) + 32768) >>> 16;
      x = longint'(est_rate[ax]);
      x = x + round_div(k * (meas - x), 65536);
      variance[ax] = (pn > 64'hFFFFFFFF) ? 32'hFFFFFFFF : pn[31:0];
      est_rate[ax] = x[24:0];
   endfunction

   function automatic void integrate_axis(int ax, longint ms, bit negate);
      longint inc, a;
      inc = round_div(longint'(est_rate[ax]) * ms * longint'(scale), 1000);
      inc = inc % ANGLE_WRAP;
      a = longint'(angle[ax]);
      a = negate ? a - inc : a + inc;
      a = a % ANGLE_WRAP;
      if (a < 0) a += ANGLE_WRAP;
      angle[ax] = a[24:0];
   endfunction

   function automatic gyro_rsp_t predict_angles(gyro_req_t r);
      gyro_rsp_t o;
      longint roll, pitch, yaw;
      roll = longint'(r.roll_raw) - longint'(ofs_roll);
      pitch = longint'(r.pitch_raw) - longint'(ofs_pitch);
      yaw = longint'(r.yaw_raw) - longint'(ofs_yaw);
      if (r.zero_yaw) angle[0] = '0;
      if (r.zero_pitch) angle[1] = '0;
      filter_axis(0, yaw);
      filter_axis(1, pitch);
      integrate_axis(0, longint'(r.ms), 1'b1);
      integrate_axis(1, longint'(r.ms), 1'b0);
      o.yaw_angle = angle[0];
      o.pitch_angle = angle[1];
      o.roll_rate = roll[24:0];
      o.pitch_rate = pitch[24:0];
      o.yaw_rate = yaw[24:0];
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [24:0] got, logic [24:0] want);
      errors++;
      $display("mismatch at rsp %0d: %s got %h want %h", n_rsps, what, got, want);
   endtask

   function automatic int unsigned pick_gap();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 600);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         gyro_req_t r;
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(predict_angles(pending_reqs.pop_front()));
            n_reqs++;
            req_gap = pick_gap();
         end
         if (!(req_valid && req_stall)) begin
            if (req_gap != 0) req_gap--;
            if (req_gap == 0 && !hold_reqs && pending_reqs.size() != 0) begin
               r = pending_reqs[0];
               req_valid <= 1'b1;
               req_roll_rate_raw <= r.roll_raw;
               req_pitch_rate_raw <= r.pitch_raw;
               req_yaw_rate_raw <= r.yaw_raw;
               req_elapsed_ms <= r.ms;
               req_zero_yaw <= r.zero_yaw;
               req_zero_pitch <= r.zero_pitch;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor with random stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         gyro_rsp_t w;
         if (rsp_valid && !rsp_stall) begin
            n_rsps++;
            if (expected_rsps.size() == 0) begin
               errors++;
               $display("unexpected rsp %0d", n_rsps);
            end else begin
               w = expected_rsps.pop_front();
               if (rsp_yaw_angle !== w.yaw_angle)
                  report_mismatch("yaw_angle", rsp_yaw_angle, w.yaw_angle);
               if (rsp_pitch_angle !== w.pitch_angle)
                  report_mismatch("pitch_angle", rsp_pitch_angle, w.pitch_angle);
               if (rsp_roll_rate !== w.roll_rate)
                  report_mismatch("roll_rate", rsp_roll_rate, w.roll_rate);
               if (rsp_pitch_rate !== w.pitch_rate)
                  report_mismatch("pitch_rate", rsp_pitch_rate, w.pitch_rate);
               if (rsp_yaw_rate !== w.yaw_rate)
                  report_mismatch("yaw_rate", rsp_yaw_rate, w.yaw_rate);
            end
         end
         if (rsp_gap != 0) begin
            rsp_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0) rsp_gap = pick_gap();
         end
      end
   end

   // watchdog on forward progress
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)
          || (pending_reqs.size() == 0 && expected_rsps.size() == 0))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired, %0d rsps outstanding", expected_rsps.size());
         $display("tb failed");
         $finish;
      end
   end

   task automatic drain();
      wait (pending_reqs.size() == 0);
      @(posedge clock);
      while (req_valid || expected_rsps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [23:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         REG_ROLL_OFS:  ofs_roll = val;
         REG_PITCH_OFS: ofs_pitch = val;
         REG_YAW_OFS:   ofs_yaw = val;
         REG_SCALE:     scale = val[15:0];
         REG_QNOISE:    q_noise = val;
         REG_RNOISE:    r_noise = val;
         default: ;
      endcase
      // csr_valid drops between writes
      @(posedge clock);
   endtask

   function automatic gyro_req_t make_req(logic [23:0] ro, logic [23:0] pi, logic [23:0] ya,
                                          logic [15:0] ms, bit zy, bit zp);
      gyro_req_t r;
      r.roll_raw = ro; r.pitch_raw = pi; r.yaw_raw = ya;
      r.ms = ms; r.zero_yaw = zy; r.zero_pitch = zp;
      return r;
   endfunction

   function automatic logic [23:0] rand_rate();
      case ($urandom_range(0, 3))
         0: return 24'($urandom);
         1: return 24'($signed($urandom_range(0, 1310720)) - 655360);
         2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
         default: return 24'($signed($urandom_range(0, 6554)) - 3277);
      endcase
   endfunction

   function automatic logic [15:0] rand_ms();
      case ($urandom_range(0, 5))
         0: return 16'($urandom);
         1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
         default: return 16'($urandom_range(0, 20));
      endcase
   endfunction

   task automatic queue_random(int n);
      repeat (n)
         pending_reqs.push_back(make_req(rand_rate(), rand_rate(), rand_rate(), rand_ms(),
                                         ($urandom_range(0, 15) == 0),
                                         ($urandom_range(0, 15) == 0)));
   endtask

   initial begin
      ofs_roll = '0; ofs_pitch = '0; ofs_yaw = '0;
      scale = 16'd6349; q_noise = 24'd6554; r_noise = 24'd655360;
      for (int i = 0; i < 2; i++) begin
         variance[i] = '0; est_rate[i] = '0; angle[i] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, zero flags, defaults
      pending_reqs.push_back(make_req(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'hFFFF, 0, 0));
      pending_reqs.push_back(make_req(24'h800000, 24'h7FFFFF, 24'h800000, 16'hFFFF, 0, 0));
      pending_reqs.push_back(make_req(24'h0, 24'h0, 24'h0, 16'h0, 1, 1));
      pending_reqs.push_back(make_req(24'h010000, 24'hFF0000, 24'h020000, 16'd10, 0, 1));
      pending_reqs.push_back(make_req(24'hFFFFFF, 24'h000001, 24'hFFFFFF, 16'd1, 1, 0));
      pending_reqs.push_back(make_req(24'h555555, 24'hAAAAAA, 24'h555555, 16'h5555, 0, 0));
      pending_reqs.push_back(make_req(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 16'hAAAA, 1, 1));
      drain();

      // offsets at extremes (rate outputs reach the full 25-bit range), R = 0
      write_csr(REG_ROLL_OFS, 24'h800000);
      write_csr(REG_PITCH_OFS, 24'h7FFFFF);
      write_csr(REG_YAW_OFS, 24'h800000);
      write_csr(REG_SCALE, 16'hFFFF);
      write_csr(REG_QNOISE, 24'hFFFFFF);
      write_csr(REG_RNOISE, 24'h0);
      pending_reqs.push_back(make_req(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'hFFFF, 0, 0));
      pending_reqs.push_back(make_req(24'h800000, 24'h7FFFFF, 24'h800000, 16'd3, 0, 0));
      queue_random(150);
      drain();

      // zero denominator: Q = R = 0 with P drained to zero
      write_csr(REG_QNOISE, 24'h0);
      write_csr(REG_SCALE, 16'h0);
      write_csr(REG_ROLL_OFS, 24'h7FFFFF);
      write_csr(REG_PITCH_OFS, 24'h800000);
      write_csr(REG_YAW_OFS, 24'h7FFFFF);
      queue_random(150);
      drain();

      // several random settings, a hold until drained in each phase
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(REG_ROLL_OFS, 24'($urandom));
         write_csr(REG_PITCH_OFS, (ph % 2) ? 24'($urandom) : 24'($urandom_range(0, 4000)));
         write_csr(REG_YAW_OFS, (ph % 2) ? 24'($urandom) : 24'($urandom_range(0, 4000)));
         write_csr(REG_SCALE, (ph == 5) ? 16'd6349 : 16'($urandom));
         write_csr(REG_QNOISE, (ph == 0) ? 24'hFFFFFF : 24'($urandom_range(0, 70000)));
         write_csr(REG_RNOISE, (ph == 1) ? 24'd1 : (ph == 2) ? 24'hFFFFFF : 24'($urandom));
         queue_random(120);
         wait (pending_reqs.size() < 60);
         hold_reqs = 1'b1;
         @(posedge clock);
         while (req_valid || expected_rsps.size() != 0) @(posedge clock);
         hold_reqs = 1'b0;
         queue_random(140);
         drain();
      end

      $display("covered %0d requests / %0d rsps over 9 register settings,", n_reqs, n_rsps);
      $display("including R=0, zero-denominator and extreme offset/scale cases");
      if (errors == 0) begin
         $display("tb passed");
      end else begin
         $display("%0d mismatches", errors);
         $display("tb failed");
      end
      $finish;
   end
endmodule
